// ===== rtl/pdo_pkg.sv =====
// Package for the power offer decoder: kinds, table size, divider length, sequencer states.
// No dependencies.
package pdo_pkg;

    localparam int MaxOffers = 8;
    localparam int SlotW = $clog2(MaxOffers);
    localparam int CntW = $clog2(MaxOffers + 1);
    // one quotient bit per step over the 30-bit dividend power*1000
    localparam int DivSteps = 30;

    typedef enum logic [2:0] {
        KIND_FIXED    = 3'd0,
        KIND_BATTERY  = 3'd1,
        KIND_VARIABLE = 3'd2,
        KIND_PROG     = 3'd3,
        KIND_ADJ      = 3'd4,
        KIND_NONE     = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDWAIT,
        ST_DECODE,
        ST_DIV,
        ST_DONE,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/power_offer_decode_and_match.sv =====
// Power offer decoder and voltage matcher, top level.
// Depends on pdo_pkg; holds the offer word table as a one-port synchronous RAM.
//
// Usage: one input item per request on i_valid/o_ready; one result item per
// request on o_valid/i_ready. A load (i_req_type 0) stores and decodes one
// offer word; a query (i_req_type 1) walks the loaded slots in order and
// returns the first valid offer containing i_query_voltage_mv (exact for
// fixed offers). i_cfg_we writes the extended-range threshold (mV).
// A battery or adjustable load, and a query whose matching offer is one,
// runs 30 steps of restoring division of power*1000 by the maximum voltage.
// A query visits the loaded slots in turn (RAM read, then decode and
// compare) until a match or the last loaded slot, then goes to the output;
// on an empty table it reads no slot.
// One item is in work at a time; the next is accepted from the cycle after
// the result handshake.
// Reset clears counts and flags and sets the threshold to 20000; the table
// needs no clearing since only slots below the load count are read. When the
// receiver stalls the result is held and no new item is accepted.
module power_offer_decode_and_match (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic        i_start_message,
    input  logic [31:0] i_pdo_word,
    input  logic [15:0] i_query_voltage_mv,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [2:0]  o_offer_kind,
    output logic [3:0]  o_slot_index,
    output logic [15:0] o_vmin_mv,
    output logic [15:0] o_vmax_mv,
    output logic [15:0] o_supply_ma,
    output logic [19:0] o_power_mw,
    output logic        o_is_extended,
    output logic        o_programmable_seen,
    output logic        o_adjustable_seen,
    output logic        o_extended_seen,
    output logic [4:0]  o_valid_count
);

    logic [31:0] r_mem [pdo_pkg::MaxOffers];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [pdo_pkg::SlotW-1:0] mem_addr;

    pdo_pkg::t_state r_state, n_state;
    logic [15:0] r_thresh;
    logic [pdo_pkg::CntW-1:0] r_loaded;
    logic [4:0]  r_vcount;
    logic [2:0]  r_flags;
    logic        r_req;
    logic [15:0] r_qv;
    logic [31:0] r_word;
    logic [pdo_pkg::SlotW-1:0] r_slot;
    logic [4:0]  r_step;

    // decoded offer
    logic        d_valid, d_ext, d_needdiv;
    pdo_pkg::t_kind d_kind;
    logic [15:0] d_vmin, d_vmax, d_cur;
    logic [19:0] d_pwr;
    logic [31:0] dw;
    logic [25:0] prod;

    logic        r_hit, r_ext, r_ovalid;
    pdo_pkg::t_kind r_kind;
    logic [15:0] r_vmin, r_vmax, r_cur;
    logic [19:0] r_pwr;
    logic [3:0]  r_oslot;

    // restoring divider: power*1000 / vmax
    logic [29:0] r_quo;
    logic [15:0] r_rem;
    logic [16:0] trial;

    logic accept, full, match;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == pdo_pkg::ST_IDLE) && !r_ovalid;
    assign full = (r_loaded == pdo_pkg::CntW'(pdo_pkg::MaxOffers));

    assign dw = (r_state == pdo_pkg::ST_DECODE && r_req) ? r_rdata : r_word;

    always_comb begin
        d_valid = 1'b1;
        d_kind = pdo_pkg::KIND_NONE;
        d_vmin = '0;
        d_vmax = '0;
        d_cur = '0;
        d_pwr = '0;
        d_ext = 1'b0;
        d_needdiv = 1'b0;
        prod = '0;
        case (dw[31:30])
            2'd0: begin
                d_kind = pdo_pkg::KIND_FIXED;
                d_vmin = 16'(dw[19:10] * 6'd50);
                d_vmax = d_vmin;
                d_cur = 16'(dw[9:0] * 4'd10);
                // 50 mV * 10 mA / 1000 is exactly half of the raw product
                prod = 26'(dw[19:10] * dw[9:0]);
                d_pwr = 20'(prod >> 1);
            end
            2'd1, 2'd2: begin
                d_kind = (dw[31:30] == 2'd1) ? pdo_pkg::KIND_BATTERY
                                              : pdo_pkg::KIND_VARIABLE;
                d_vmax = 16'(dw[29:20] * 6'd50);
                d_vmin = 16'(dw[19:10] * 6'd50);
                if (dw[31:30] == 2'd1) begin
                    d_pwr = 20'(dw[9:0] * 8'd250);
                    d_needdiv = 1'b1;
                end else begin
                    d_cur = 16'(dw[9:0] * 4'd10);
                    prod = 26'(dw[29:20] * dw[9:0]);
                    d_pwr = 20'(prod >> 1);
                end
            end
            default: begin
                if (dw[29:28] == 2'd0) begin
                    d_kind = pdo_pkg::KIND_PROG;
                    d_vmax = 16'(dw[24:17] * 7'd100);
                    d_vmin = 16'(dw[15:8] * 7'd100);
                    d_cur = 16'(dw[6:0] * 6'd50);
                    // 100 mV * 50 mA / 1000 is five times the raw product
                    prod = 26'(dw[24:17] * dw[6:0]);
                    d_pwr = 20'(prod * 3'd5);
                end else if (dw[29:28] == 2'd1) begin
                    d_kind = pdo_pkg::KIND_ADJ;
                    d_vmax = 16'(dw[25:17] * 7'd100);
                    d_vmin = 16'(dw[15:8] * 7'd100);
                    d_pwr = 20'(dw[7:0] * 10'd1000);
                    d_needdiv = 1'b1;
                end else begin
                    d_valid = 1'b0;
                end
            end
        endcase
        if (dw == '0) begin
            d_valid = 1'b0;
        end
        if (d_kind == pdo_pkg::KIND_ADJ) begin
            d_ext = 1'b1;
        end else if (d_kind != pdo_pkg::KIND_PROG) begin
            d_ext = d_vmax > r_thresh;
        end
        if (!d_valid) begin
            d_kind = pdo_pkg::KIND_NONE;
            d_vmin = '0;
            d_vmax = '0;
            d_cur = '0;
            d_pwr = '0;
            d_ext = 1'b0;
            d_needdiv = 1'b0;
        end
    end

    assign match = d_valid && ((d_kind == pdo_pkg::KIND_FIXED) ? (r_qv == d_vmin)
                   : (r_qv >= d_vmin && r_qv <= d_vmax));

    assign trial = {r_rem, r_quo[29]} - {1'b0, r_vmax};

    assign mem_we = (r_state == pdo_pkg::ST_DECODE) && !r_req;
    assign mem_addr = r_slot;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_word;
        end
        r_rdata <= r_mem[mem_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pdo_pkg::ST_IDLE:   if (accept) n_state = pdo_pkg::ST_RDWAIT;
            pdo_pkg::ST_RDWAIT: begin
                if (r_req && r_loaded == '0) n_state = pdo_pkg::ST_DONE;
                else if (!r_req && full) n_state = pdo_pkg::ST_DONE;
                else n_state = pdo_pkg::ST_DECODE;
            end
            pdo_pkg::ST_DECODE: begin
                if (!r_req || match) begin
                    n_state = d_needdiv ? pdo_pkg::ST_DIV : pdo_pkg::ST_DONE;
                end else if ({1'b0, r_slot} + 1'b1 >= r_loaded) begin
                    n_state = pdo_pkg::ST_DONE;
                end else begin
                    n_state = pdo_pkg::ST_RDWAIT;
                end
            end
            pdo_pkg::ST_DIV: begin
                if (r_step == 5'(pdo_pkg::DivSteps - 1)) n_state = pdo_pkg::ST_DONE;
            end
            pdo_pkg::ST_DONE: n_state = pdo_pkg::ST_OUT;
            pdo_pkg::ST_OUT:  n_state = pdo_pkg::ST_IDLE;
            default:          n_state = pdo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdo_pkg::ST_IDLE;
            r_thresh <= 16'd20000;
            r_loaded <= '0;
            r_vcount <= '0;
            r_flags <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_thresh <= i_cfg_data;
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (r_state == pdo_pkg::ST_OUT) r_ovalid <= 1'b1;
            if (accept && !i_req_type && i_start_message) begin
                r_loaded <= '0;
                r_vcount <= '0;
                r_flags <= '0;
            end
            if (r_state == pdo_pkg::ST_DECODE && !r_req) begin
                r_loaded <= r_loaded + 1'b1;
                if (d_valid) begin
                    r_vcount <= r_vcount + 1'b1;
                    r_flags <= r_flags | {d_ext, d_kind == pdo_pkg::KIND_ADJ,
                                          d_kind == pdo_pkg::KIND_PROG};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            pdo_pkg::ST_IDLE: if (accept) begin
                r_req <= i_req_type;
                r_qv <= i_query_voltage_mv;
                r_word <= i_pdo_word;
                r_slot <= (!i_req_type && !i_start_message)
                        ? r_loaded[pdo_pkg::SlotW-1:0] : '0;
                r_hit <= 1'b0;
                r_kind <= pdo_pkg::KIND_NONE;
                r_oslot <= '0;
                r_vmin <= '0;
                r_vmax <= '0;
                r_cur <= '0;
                r_pwr <= '0;
                r_ext <= 1'b0;
            end
            pdo_pkg::ST_DECODE: begin
                if (!r_req || match) begin
                    r_hit <= d_valid;
                    r_kind <= d_kind;
                    r_oslot <= 4'(r_slot);
                    r_vmin <= d_vmin;
                    r_vmax <= d_vmax;
                    r_cur <= d_cur;
                    r_pwr <= d_pwr;
                    r_ext <= d_ext;
                    r_quo <= 30'(d_pwr * 10'd1000);
                    r_rem <= '0;
                    r_step <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            pdo_pkg::ST_DIV: begin
                r_step <= r_step + 1'b1;
                if (!trial[16]) begin
                    r_rem <= trial[15:0];
                    r_quo <= {r_quo[28:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[14:0], r_quo[29]};
                    r_quo <= {r_quo[28:0], 1'b0};
                end
            end
            pdo_pkg::ST_DONE: begin
                // all dividend bits have been shifted through; r_quo is the full quotient
                if (r_kind == pdo_pkg::KIND_BATTERY || r_kind == pdo_pkg::KIND_ADJ) begin
                    if (r_vmax == '0 || r_quo[29:16] != '0) r_cur <= 16'hFFFF;
                    else r_cur <= r_quo[15:0];
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_hit = r_hit;
    assign o_offer_kind = r_kind;
    assign o_slot_index = r_oslot;
    assign o_vmin_mv = r_vmin;
    assign o_vmax_mv = r_vmax;
    assign o_supply_ma = r_cur;
    assign o_power_mw = r_pwr;
    assign o_is_extended = r_ext;
    assign o_programmable_seen = r_flags[0];
    assign o_adjustable_seen = r_flags[1];
    assign o_extended_seen = r_flags[2];
    assign o_valid_count = r_vcount;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcount <= 5'(r_loaded))
        else $error("valid count above loaded slots");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !o_ready)
        else $error("input taken while result pending");
    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_power_mw == '0 && o_supply_ma == '0))
        else $error("miss carries offer data");

endmodule
